@@ sv/assert_macros.svh @@
// Assertion macros used by the allocator core RTL.
// Defining ASSERT_OFF leaves every macro body empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

@@ sv/tlba_pkg.sv @@
// Package for the two-level bitmap identifier allocator.
// Holds pool sizes, word layouts and request codes; depends on nothing.
package tlba_pkg;

  // Number of 16-identifier groups in the pool (2 to 16).
  localparam int NUM_GROUPS = 16;
  localparam int GROUP_BITS = 16;
  localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  localparam logic [GROUP_BITS-1:0] WORD_ALL_ONES = '1;
  // Marks of groups beyond the pool read as full.
  localparam logic [GROUP_BITS-1:0] PAD_MASK = 16'(32'hFFFF << NUM_GROUPS);

  // Request codes.
  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_t;

  // Input word: req_type in bit 0, free_id in bits 8..1.
  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] free_id;
    req_type_t  req_type;
  } in_word_t;

  // Result word: granted in bit 0, given_id in bits 8..1.
  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] given_id;
    logic       granted;
  } out_word_t;

endpackage

@@ sv/two_level_bitmap_id_allocator_core.sv @@
// Channel   | Dir | Word fields (low bit up)                 | Accepted when
// in_*      | in  | req_type[0], free_id[8:1], zero pad      | in_tvalid && in_tready
// out_*     | out | granted[0], given_id[8:1], zero pad      | out_tvalid && out_tready
//
// Each request passes an input register, then priority encoding and bitmap update,
// then the result register: one request per cycle while the result is not stalled.
// The group-mark and used-bit registers update as a request moves into the result
// register, so the next request sees them at once. Reset (synchronous, rst_n low)
// frees every identifier. A stalled result holds the input register, which still
// takes a word while it is empty.
`include "assert_macros.svh"
module two_level_bitmap_id_allocator_core
  import tlba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // req_type[0], free_id[8:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // granted[0], given_id[8:1]
);

  // Input register.
  logic     s1_valid_r;
  in_word_t s1_word_r;
  logic     s1_adv;

  // Result register.
  logic      out_valid_r;
  out_word_t out_word_r, out_word_nxt;

  // Allocator state.
  logic [GROUP_BITS-1:0] used_r [NUM_GROUPS];
  logic [GROUP_BITS-1:0] used_nxt [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] full_r, full_nxt;

  // Picker results.
  logic                  grp_found, bit_found;
  logic [3:0]            grp_idx, bit_idx;
  logic [GROUP_BITS-1:0] marks_ext, sel_word, set_word;
  logic [GRP_W-1:0]      agrp;
  logic [3:0]            fgrp_full, fbit;
  logic [GRP_W-1:0]      fgrp;
  logic                  free_in_pool;
  logic                  marks_ok;

  // Handshake: the input register advances when the result register is free or being taken.
  assign s1_adv     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;

  // Group picker over the full marks, then bit picker over the chosen word.
  assign marks_ext = GROUP_BITS'(full_r) | PAD_MASK;

  tlba_pick u_grp_pick (
    .word  (marks_ext),
    .found (grp_found),
    .idx   (grp_idx)
  );

  assign agrp     = grp_idx[GRP_W-1:0];
  assign sel_word = used_r[agrp];

  tlba_pick u_bit_pick (
    .word  (sel_word),
    .found (bit_found),
    .idx   (bit_idx)
  );

  assign set_word = sel_word | (GROUP_BITS'(1) << bit_idx);

  // Free request fields.
  assign fgrp_full    = s1_word_r.free_id[7:4];
  assign fbit         = s1_word_r.free_id[3:0];
  assign fgrp         = fgrp_full[GRP_W-1:0];
  assign free_in_pool = {1'b0, fgrp_full} < 5'(NUM_GROUPS);

  // Next state and result for the request in the input register.
  always_comb begin
    used_nxt     = used_r;
    full_nxt     = full_r;
    out_word_nxt = '0;
    if (s1_word_r.req_type == REQ_FREE) begin
      out_word_nxt.granted = 1'b1;
      if (free_in_pool) begin
        used_nxt[fgrp][fbit] = 1'b0;
        full_nxt[fgrp]       = 1'b0;
      end
    end else if (grp_found) begin
      if (!bit_found) begin
        // Marked-free group with a full word: repair the mark, deny.
        full_nxt[agrp] = 1'b1;
      end else begin
        used_nxt[agrp] = set_word;
        if (set_word == WORD_ALL_ONES) begin
          full_nxt[agrp] = 1'b1;
        end
        out_word_nxt.granted  = 1'b1;
        out_word_nxt.given_id = {grp_idx, bit_idx};
      end
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      full_r      <= '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        used_r[g] <= '0;
      end
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        full_r      <= full_nxt;
        used_r      <= used_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_word_r <= in_tdata;
    end
    if (s1_adv) begin
      out_word_r <= out_word_nxt;
    end
  end

  // A group's full mark matches its word being all ones.
  always_comb begin
    marks_ok = 1'b1;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (full_r[g] != (used_r[g] == WORD_ALL_ONES)) begin
        marks_ok = 1'b0;
      end
    end
  end

  `ASSERT_ALWAYS(a_marks_match, clk, rst_n, marks_ok, "full mark disagrees with group word")
  `ASSERT_IMPLY(a_deny_zero_id, clk, rst_n, out_valid_r && !out_word_r.granted, out_word_r.given_id == 8'd0, "denied result carries an identifier")
  `ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid_r, in_tready, "input stalled while result register is empty")

endmodule

@@ sv/tlba_pick.sv @@
// Lowest-clear-bit finder over one 16-bit word.
// Uses tlba_pkg for the word width; instantiated by the allocator core.
module tlba_pick
  import tlba_pkg::*;
(
  input  logic [GROUP_BITS-1:0] word,
  output logic                  found,
  output logic [3:0]            idx
);

  logic [GROUP_BITS-1:0] first_zero;

  // Isolate the lowest clear bit as a one-hot vector.
  assign first_zero = ~word & (word + GROUP_BITS'(1));
  assign found      = ~&word;

  // Encode the one-hot vector to an index.
  always_comb begin
    idx = '0;
    for (int i = 0; i < GROUP_BITS; i++) begin
      if (first_zero[i]) begin
        idx = idx | 4'(i);
      end
    end
  end

endmodule

@@ bench/id_grant_checker.sv @@
// Checker for the two-level bitmap identifier allocator: watches both stream channels,
// predicts each result word from its own copy of the bitmaps, and compares in order.
// Depends on tlba_pkg for the word layouts, request codes and pool size.
`timescale 1ns / 1ps
module id_grant_checker
  import tlba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // req_type[0], free_id[8:1]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // granted[0], given_id[8:1]
  output int          mismatch_count,
  output int          outstanding
);

  // Groups actually backed by storage; group fields at or above this are ignored.
  localparam int POOL_GROUPS = (NUM_GROUPS > 16) ? 16 : ((NUM_GROUPS < 1) ? 1 : NUM_GROUPS);

  // Shadow copy of the allocator state.
  logic [GROUP_BITS-1:0] used_bits [0:15];
  logic [15:0]           full_marks;

  // Result words predicted but not yet seen on the output channel.
  out_word_t grant_queue[$];

  // Apply one request to the shadow bitmaps and return the word it should produce.
  function automatic out_word_t serve_request(in_word_t req);
    out_word_t  res;
    logic [3:0] grp_sel;
    logic [3:0] slot_sel;
    int         grp;
    int         slot;
    res = '0;
    if (req.req_type == REQ_FREE) begin
      grp_sel  = req.free_id[7:4];
      slot_sel = req.free_id[3:0];
      if (int'(grp_sel) < POOL_GROUPS) begin
        used_bits[grp_sel][slot_sel] = 1'b0;
        full_marks[grp_sel]          = 1'b0;
      end
      res.granted = 1'b1;
      return res;
    end
    // Lowest group whose full mark is clear.
    grp = POOL_GROUPS;
    for (int i = POOL_GROUPS - 1; i >= 0; i--)
      if (!full_marks[i]) grp = i;
    if (grp >= POOL_GROUPS) return res;
    // Lowest free identifier inside that group.
    slot = GROUP_BITS;
    for (int i = GROUP_BITS - 1; i >= 0; i--)
      if (!used_bits[grp][i]) slot = i;
    if (slot >= GROUP_BITS) begin
      full_marks[grp] = 1'b1;
      return res;
    end
    used_bits[grp][slot] = 1'b1;
    if (used_bits[grp] == WORD_ALL_ONES) full_marks[grp] = 1'b1;
    res.granted  = 1'b1;
    res.given_id = 8'((grp << 4) + slot);
    return res;
  endfunction

  // Check result words first, then queue the prediction for a newly accepted request.
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (!rst_n) begin
      for (int g = 0; g < 16; g++) used_bits[g] = '0;
      full_marks = '0;
      grant_queue.delete();
      mismatch_count = 0;
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_word_t'(out_tdata);
        if (grant_queue.size() == 0) begin
          $display("%0t: unexpected result word granted=%0d given_id=%0d", $time,
                   got.granted, got.given_id);
          mismatch_count++;
        end else begin
          want = grant_queue.pop_front();
          if (got.granted !== want.granted || got.given_id !== want.given_id ||
              got.pad !== want.pad) begin
            $display("%0t: result mismatch: expected granted=%0d given_id=%0d pad=%0h, actual granted=%0d given_id=%0d pad=%0h",
                     $time, want.granted, want.given_id, want.pad,
                     got.granted, got.given_id, got.pad);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) grant_queue.push_back(serve_request(in_word_t'(in_tdata)));
      outstanding <= grant_queue.size();
    end
  end

endmodule

@@ bench/two_level_bitmap_id_allocator_core_tb.sv @@
// Top of the allocator testbench: clock, reset, request stimulus and output stalls.
// Depends on tlba_pkg, two_level_bitmap_id_allocator_core and id_grant_checker.
`timescale 1ns / 1ps
module two_level_bitmap_id_allocator_core_tb;
  import tlba_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // req_type[0], free_id[8:1]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // granted[0], given_id[8:1]

  int mismatch_count;
  int outstanding;
  int burst_left;
  int idle_cycles;
  bit hold_request;
  bit hold_served;

  two_level_bitmap_id_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  id_grant_checker grant_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  // 100 MHz clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one request word and wait for it to be taken; bursts end in a random gap.
  task automatic issue(input req_type_t kind, input logic [7:0] id);
    in_word_t w;
    w          = '0;
    w.req_type = kind;
    w.free_id  = id;
    in_tdata  <= w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  // Stop offering and wait until every predicted result word has come out.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // A run of random requests; alloc_pct sets the share of allocations.
  task automatic run_phase(input int count, input int alloc_pct);
    repeat (count)
      issue(($urandom_range(0, 99) < alloc_pct) ? REQ_ALLOC : REQ_FREE,
            8'($urandom_range(0, 255)));
    wait_for_results();
  endtask

  // Receiver: mixes open stretches, random toggling and stalls, plus one long hold-off.
  initial begin
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      int pick;
      pick = $urandom_range(0, 9);
      if (hold_request && !hold_served) begin
        out_tready <= 1'b0;
        repeat (120) @(posedge clk);
        hold_served = 1'b1;
      end else if (pick < 4) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end else if (pick < 8) begin
        repeat ($urandom_range(4, 40)) begin
          out_tready <= 1'($urandom_range(0, 1));
          @(posedge clk);
        end
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    burst_left   = 3;
    hold_request = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: frees of identifiers that are already free, the lowest and highest ids,
    // allocations that reuse a released slot, and alternating bit patterns.
    issue(REQ_FREE, 8'h00);
    issue(REQ_FREE, 8'hFF);
    issue(REQ_ALLOC, 8'hFF);
    issue(REQ_ALLOC, 8'h00);
    issue(REQ_ALLOC, 8'hAA);
    issue(REQ_FREE, 8'h01);
    issue(REQ_ALLOC, 8'h55);
    issue(REQ_FREE, 8'hAA);
    issue(REQ_FREE, 8'h55);
    issue(REQ_FREE, 8'h00);
    issue(REQ_ALLOC, 8'h00);
    issue(REQ_ALLOC, 8'h00);
    issue(REQ_FREE, 8'h02);
    issue(REQ_FREE, 8'h02);
    issue(REQ_ALLOC, 8'h0F);
    issue(REQ_FREE, 8'hF0);
    wait_for_results();

    // Random: fill past exhaustion, churn near full, then release most of the pool.
    for (int round = 0; round < 2; round++) begin
      run_phase(300, 95);
      hold_request = 1'b1;
      run_phase(150, 50);
      run_phase(180, 8);
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/tlba_pkg.sv
sv/tlba_pick.sv
sv/two_level_bitmap_id_allocator_core.sv
bench/id_grant_checker.sv
bench/two_level_bitmap_id_allocator_core_tb.sv
